// File: rtl/segment_box_occlusion_test_unit_macros.svh
// Assertion macros for the segment box occlusion test unit
`ifndef SEGMENT_BOX_OCCLUSION_TEST_UNIT_MACROS_SVH
`define SEGMENT_BOX_OCCLUSION_TEST_UNIT_MACROS_SVH
// implication checked on every edge outside reset
`define SBOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SBOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/sbot_pkg.sv
// Package for the segment box occlusion test unit: types, constants, states
package sbot_pkg;
	localparam int MaxBoxes = 64;
	localparam int IdxW = $clog2(MaxBoxes);
	localparam int CntW = $clog2(MaxBoxes + 1);
	localparam int QW = 19;
	localparam int NumW = 18;
	localparam int DenW = 16;
	localparam int QuoW = 17;
	localparam logic signed [QW-1:0] SatQ = 19'sd131072;
	localparam logic signed [QW-1:0] OneQ = 19'sd65536;
	localparam logic [0:0] CmdLoad = 1'b0;
	localparam logic [0:0] CmdQuery = 1'b1;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0] width;
		logic [14:0] height;
	} box_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_AXIS,
		ST_DIV,
		ST_NARROW,
		ST_DONE
	} state_t;
endpackage

// File: rtl/segment_box_occlusion_test_unit.sv
// Top level of the segment box occlusion test unit
//
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------
// input    | in_valid / in_ready | cmd, box_index, box_*, from_*, to_*
// output   | out_valid/out_ready | sight_clear
// config   | cfg_we              | cfg_wdata (boxes_in_use)
//
// A load is taken in ST_IDLE; in_ready stays high for the next word.
// A query reads the table once per box, then per ratio runs one setup state, the
// 17 quotient bits of the shared restoring divider and one narrowing state, two
// ratios per axis. A zero-extent axis is settled in the setup state alone, and the
// query stops at the first blocking box.
// Reset clears control state only; the box table is undefined until written.
// in_ready is low while a query runs; a finished query holds in ST_DONE only while
// the previous word still waits on out_ready.
module segment_box_occlusion_test_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [5:0]  box_index,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic [14:0] box_width,
	input  logic [14:0] box_height,
	input  logic signed [15:0] from_x,
	input  logic signed [15:0] from_y,
	input  logic signed [15:0] to_x,
	input  logic signed [15:0] to_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sight_clear,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
`include "segment_box_occlusion_test_unit_macros.svh"

	sbot_pkg::box_t mem [sbot_pkg::MaxBoxes];
	sbot_pkg::box_t rd_q;
	logic [6:0] cfg_q;
	sbot_pkg::state_t state_q, state_d;
	logic [sbot_pkg::CntW-1:0] idx_q;
	logic [sbot_pkg::CntW-1:0] count;
	logic axis_q;
	logic sel_q;
	logic signed [15:0] fx_q, fy_q, tx_q, ty_q;
	logic signed [sbot_pkg::QW-1:0] lo_q, hi_q, t1_q;
	logic [sbot_pkg::NumW-1:0] rem_q;
	logic [sbot_pkg::QuoW-1:0] quo_q;
	logic [sbot_pkg::DenW-1:0] den_q;
	logic neg_q;
	logic [4:0] bit_q;
	logic clear_q;
	logic ovl_q;

	logic accept, is_load, out_load;
	logic signed [15:0] st, en, low;
	logic [14:0] size;
	logic signed [16:0] d, high;
	logic signed [17:0] edge_v, num;
	logic [sbot_pkg::NumW-1:0] an;
	logic [sbot_pkg::DenW-1:0] dn;
	logic [sbot_pkg::NumW-1:0] rem_sh;
	logic [sbot_pkg::NumW:0] trial;
	logic signed [sbot_pkg::QW-1:0] mag, tq, ta, tb, nlo, nhi;
	logic outside;
	logic decide, reject, box_miss, box_hit, next_axis;

	assign accept = in_valid && in_ready;
	assign is_load = (cmd == sbot_pkg::CmdLoad);
	assign count = (cfg_q > 7'(sbot_pkg::MaxBoxes)) ?
		sbot_pkg::CntW'(sbot_pkg::MaxBoxes) : sbot_pkg::CntW'(cfg_q);
	assign in_ready = (state_q == sbot_pkg::ST_IDLE);
	assign out_load = (state_q == sbot_pkg::ST_DONE) && (!out_valid || out_ready);

	always_comb begin
		st = axis_q ? fy_q : fx_q;
		en = axis_q ? ty_q : tx_q;
		low = axis_q ? rd_q.top : rd_q.left;
		size = axis_q ? rd_q.height : rd_q.width;
		d = 17'(en) - 17'(st);
		high = 17'(low) + 17'({1'b0, size});
		outside = (17'(st) < 17'(low)) || (17'(st) > high);
		edge_v = sel_q ? 18'(high) : 18'(low);
		num = edge_v - 18'(st);
		an = num[17] ? 18'(-num) : 18'(num);
		dn = d[16] ? sbot_pkg::DenW'(-d) : sbot_pkg::DenW'(d);
		rem_sh = (bit_q == 5'(sbot_pkg::QuoW - 1)) ? rem_q :
			{rem_q[sbot_pkg::NumW-2:0], 1'b0};
		trial = {1'b0, rem_sh} - {{(sbot_pkg::NumW - sbot_pkg::DenW + 1){1'b0}}, den_q};
		mag = ovl_q ? sbot_pkg::SatQ : sbot_pkg::QW'(quo_q);
		tq = neg_q ? -mag : mag;
		ta = (t1_q > tq) ? tq : t1_q;
		tb = (t1_q > tq) ? t1_q : tq;
		nlo = (ta > lo_q) ? ta : lo_q;
		nhi = (tb < hi_q) ? tb : hi_q;
	end

	// box verdict: zero-extent axis in ST_AXIS, window check after the second ratio
	assign decide = ((state_q == sbot_pkg::ST_AXIS) && (d == 17'sd0)) ||
		((state_q == sbot_pkg::ST_NARROW) && sel_q);
	assign reject = (state_q == sbot_pkg::ST_AXIS) ? outside : (nlo > nhi);
	assign box_miss = decide && reject;
	assign box_hit = decide && !reject && axis_q;
	assign next_axis = decide && !reject && !axis_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbot_pkg::ST_IDLE: if (accept && !is_load) state_d = sbot_pkg::ST_READ;
			sbot_pkg::ST_READ: state_d = (idx_q == count) ? sbot_pkg::ST_DONE :
				sbot_pkg::ST_AXIS;
			sbot_pkg::ST_AXIS, sbot_pkg::ST_NARROW: begin
				priority if (box_miss) state_d = sbot_pkg::ST_READ;
				else if (box_hit) state_d = sbot_pkg::ST_DONE;
				else if (state_q == sbot_pkg::ST_AXIS && d != 17'sd0)
					state_d = sbot_pkg::ST_DIV;
				else state_d = sbot_pkg::ST_AXIS;
			end
			sbot_pkg::ST_DIV: if (bit_q == 5'd0) state_d = sbot_pkg::ST_NARROW;
			sbot_pkg::ST_DONE: if (out_load) state_d = sbot_pkg::ST_IDLE;
			default: state_d = sbot_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && is_load)
			mem[box_index[sbot_pkg::IdxW-1:0]] <= '{box_left, box_top, box_width, box_height};
		rd_q <= mem[idx_q[sbot_pkg::IdxW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbot_pkg::ST_IDLE;
			cfg_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			axis_q <= 1'b0;
			sel_q <= 1'b0;
			clear_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q <= cfg_wdata;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				sbot_pkg::ST_IDLE: begin
					idx_q <= '0;
					axis_q <= 1'b0;
					sel_q <= 1'b0;
					clear_q <= 1'b1;
				end
				sbot_pkg::ST_READ: begin
					axis_q <= 1'b0;
					sel_q <= 1'b0;
				end
				sbot_pkg::ST_AXIS, sbot_pkg::ST_NARROW: begin
					if (state_q == sbot_pkg::ST_NARROW) sel_q <= !sel_q;
					if (box_miss) idx_q <= idx_q + 1'b1;
					if (box_hit) clear_q <= 1'b0;
					if (next_axis) axis_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) sight_clear <= clear_q;
		unique case (state_q)
			sbot_pkg::ST_READ: begin
				lo_q <= '0;
				hi_q <= sbot_pkg::OneQ;
			end
			sbot_pkg::ST_AXIS: begin
				neg_q <= num[17] ^ d[16];
				rem_q <= an;
				den_q <= dn;
				quo_q <= '0;
				ovl_q <= (an >= {1'b0, dn, 1'b0});
				bit_q <= 5'(sbot_pkg::QuoW - 1);
			end
			sbot_pkg::ST_DIV: begin
				bit_q <= bit_q - 1'b1;
				if (!trial[sbot_pkg::NumW]) rem_q <= trial[sbot_pkg::NumW-1:0];
				else rem_q <= rem_sh;
				quo_q <= {quo_q[sbot_pkg::QuoW-2:0], !trial[sbot_pkg::NumW]};
			end
			sbot_pkg::ST_NARROW: begin
				if (!sel_q) begin
					t1_q <= tq;
				end else begin
					lo_q <= nlo;
					hi_q <= nhi;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fx_q <= from_x;
			fy_q <= from_y;
			tx_q <= to_x;
			ty_q <= to_y;
		end
	end

	`SBOT_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != sbot_pkg::ST_IDLE, !in_ready)
	`SBOT_ASSERT_NXT(a_done_gives_result, clk, arst_n, state_q == sbot_pkg::ST_DONE, out_valid)
	`SBOT_ASSERT_NXT(a_load_no_busy, clk, arst_n, accept && is_load,
		state_q == sbot_pkg::ST_IDLE)
	`SBOT_ASSERT_IMP(a_idx_bound, clk, arst_n, state_q == sbot_pkg::ST_DIV,
		idx_q < sbot_pkg::CntW'(sbot_pkg::MaxBoxes))
endmodule

// File: verif/segment_box_occlusion_test_unit_checker.sv
// Checker for the segment box occlusion test unit: predicts visibility and compares words
module segment_box_occlusion_test_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        cmd,
	input  logic [5:0]  box_index,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic [14:0] box_width,
	input  logic [14:0] box_height,
	input  logic signed [15:0] from_x,
	input  logic signed [15:0] from_y,
	input  logic signed [15:0] to_x,
	input  logic signed [15:0] to_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        sight_clear,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	sbot_pkg::box_t boxes [sbot_pkg::MaxBoxes];
	logic [6:0] boxes_in_use;
	bit        clear_q [$];

	function automatic longint slab_ratio(longint num, longint den);
		longint q;
		q = (num * 65536) / den;
		if (q > 131072) q = 131072;
		if (q < -131072) q = -131072;
		return q;
	endfunction

	function automatic bit slab_pass(longint s, longint e, longint low, longint size,
			inout longint lo, inout longint hi);
		longint d, high, t1, t2, tmp;
		d = e - s;
		high = low + size;
		if (d == 0) return !(s < low || s > high);
		t1 = slab_ratio(low - s, d);
		t2 = slab_ratio(high - s, d);
		if (t1 > t2) begin
			tmp = t1; t1 = t2; t2 = tmp;
		end
		if (t1 > lo) lo = t1;
		if (t2 < hi) hi = t2;
		return lo <= hi;
	endfunction

	function automatic bit sight_is_clear(longint fx, longint fy, longint tx, longint ty);
		int n;
		longint lo, hi;
		n = boxes_in_use > sbot_pkg::MaxBoxes ? sbot_pkg::MaxBoxes : int'(boxes_in_use);
		for (int i = 0; i < n; i++) begin
			lo = 0;
			hi = 65536;
			if (!slab_pass(fx, tx, boxes[i].left, boxes[i].width, lo, hi)) continue;
			if (!slab_pass(fy, ty, boxes[i].top, boxes[i].height, lo, hi)) continue;
			return 0;
		end
		return 1;
	endfunction

	assign pending = clear_q.size();

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			boxes_in_use <= '0;
			fail_count <= 0;
			clear_q.delete();
		end else begin
			if (cfg_we) boxes_in_use <= cfg_wdata;
			if (in_valid && in_ready) begin
				if (cmd == sbot_pkg::CmdLoad)
					boxes[box_index] <= '{box_left, box_top, box_width, box_height};
				else
					clear_q = {clear_q, sight_is_clear(from_x, from_y, to_x, to_y)};
			end
			if (out_valid && out_ready) begin
				if (clear_q.size() == 0) begin
					$display("%0t: unexpected word, actual sight_clear=%0d", $time, sight_clear);
					fail_count <= fail_count + 1;
				end else begin
					want = clear_q.pop_front();
					if (want !== sight_clear) begin
						$display("%0t: sight_clear expected %0d actual %0d", $time, want,
							sight_clear);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: verif/segment_box_occlusion_test_unit_test.sv
// Testbench top for the segment box occlusion test unit: stimulus and verdict
module segment_box_occlusion_test_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0, cfg_we = 0;
	logic cmd = 0;
	logic [5:0] box_index = 0;
	logic signed [15:0] box_left = 0, box_top = 0;
	logic [14:0] box_width = 0, box_height = 0;
	logic signed [15:0] from_x = 0, from_y = 0, to_x = 0, to_y = 0;
	logic [6:0] cfg_wdata = 0;
	logic in_ready, out_valid, sight_clear;
	int fail_count, pending;
	int send_idle = 0, recv_idle = 0;
	int quiet = 0;
	logic [6:0] loaded = 0;

	always #2 clk = ~clk;

	segment_box_occlusion_test_unit u_dut (.*);
	segment_box_occlusion_test_unit_checker u_chk (.*);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_word(logic c, int idx, int l, int t, int w, int h,
			int fx, int fy, int tx, int ty);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c; box_index <= 6'(idx); box_left <= 16'(l); box_top <= 16'(t);
		box_width <= 15'(w); box_height <= 15'(h); from_x <= 16'(fx); from_y <= 16'(fy);
		to_x <= 16'(tx); to_y <= 16'(ty); in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		if (c == sbot_pkg::CmdLoad && idx >= int'(loaded)) loaded = 7'(idx + 1);
	endtask

	task automatic load_box(int idx, int l, int t, int w, int h);
		send_word(sbot_pkg::CmdLoad, idx, l, t, w, h, int'($urandom), int'($urandom),
			int'($urandom), int'($urandom));
	endtask

	task automatic query(int fx, int fy, int tx, int ty);
		send_word(sbot_pkg::CmdQuery, int'($urandom), int'($urandom), int'($urandom),
			int'($urandom), int'($urandom), fx, fy, tx, ty);
	endtask

	task automatic set_in_use(int n);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		cfg_wdata <= 7'(n); cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int rand_coord();
		case ($urandom_range(3))
			0: return int'($urandom);
			1: return int'($urandom_range(0, 1023)) - 512;
			2: return $urandom_range(0, 7) != 0 ? int'($urandom_range(0, 255)) - 128
				: -32768;
			default: return $urandom_range(0, 1) != 0 ? 32767 : -32768;
		endcase
	endfunction

	task automatic random_phase(int n, int sidle, int ridle);
		int fx, fy;
		send_idle = sidle; recv_idle = ridle;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				load_box((loaded < 7'd64 && $urandom_range(1) != 0) ? int'(loaded)
					: int'($urandom_range(0, 63)), rand_coord(), rand_coord(),
					$urandom_range(0, 3) != 0 ? int'($urandom_range(0, 600)) : int'($urandom),
					$urandom_range(0, 3) != 0 ? int'($urandom_range(0, 600)) : int'($urandom));
			end else begin
				fx = rand_coord(); fy = rand_coord();
				case ($urandom_range(3))
					0: query(fx, fy, fx, rand_coord());
					1: query(fx, fy, rand_coord(), fy);
					default: query(fx, fy, rand_coord(), rand_coord());
				endcase
			end
			if ($urandom_range(29) == 0) begin
				set_in_use($urandom_range(0, 3) == 0 ? int'($urandom_range(0, 127))
					: int'($urandom_range(0, loaded > 7'd8 ? 8 : int'(loaded))));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle = 26; recv_idle = 47;
		query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		load_box(0, 0, 0, 160, 160);
		load_box(1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
		load_box(2, 16'h7fff, 16'h7fff, 0, 0);
		load_box(3, -320, 200, 15'h7fff, 0);
		set_in_use(1);
		query(-160, 80, 320, 80);
		query(-160, 400, 320, 400);
		query(0, -80, 0, 320);
		query(160, -80, 160, 320);
		query(161, -80, 161, 320);
		query(80, 80, 80, 80);
		query(-1, -1, -1, -1);
		query(16'h8000, 50, 16'h7fff, 51);
		set_in_use(4);
		query(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		query(-1000, 200, 1000, 200);
		query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		set_in_use(127);
		for (int i = 4; i < 64; i++) load_box(i, 20000, 20000, 1, 1);
		load_box(63, 16'h7fff, 16'h8000, 15'h7fff, 15'h7fff);
		query(20000, 20000, 20001, 20001);
		query(30000, 30000, 30001, 30001);
		set_in_use(64);
		random_phase(124, 26, 47);
		random_phase(124, 47, 26);
		random_phase(124, 0, 0);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
